FILE: src/char_lcd_nibble_bus_sequencer_macros.svh
// Assertion macros shared by the display sequencer RTL.
`ifndef CHAR_LCD_NIBBLE_BUS_SEQUENCER_MACROS_SVH
`define CHAR_LCD_NIBBLE_BUS_SEQUENCER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising edge out of reset
`define CLNBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sequencer check failed");

// Next-cycle implication
`define CLNBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sequencer check failed");

`else

`define CLNBS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CLNBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/clnbs_pkg.sv
// Types, codes, constants and init tables for the display nibble-bus sequencer.
`default_nettype none

package clnbs_pkg;

	// Request codes carried in the input tuser
	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_INIT  = 3'd1,
		OP_CMD   = 3'd2,
		OP_DATA  = 3'd3,
		OP_ADDR  = 3'd4,
		OP_READ  = 3'd5
	} op_t;

	// Extra wait that follows a nibble
	typedef enum logic [1:0] {
		WK_NONE  = 2'd0,
		WK_POWER = 2'd1,
		WK_SHORT = 2'd2,
		WK_CLEAR = 2'd3
	} wait_kind_t;

	localparam int unsigned COUNT_WIDTH_DEF = 16;
	localparam int unsigned CFG_WIDTH       = 16;
	localparam int unsigned CFG_IDX_WIDTH   = 2;

	// Register indexes
	localparam logic [CFG_IDX_WIDTH-1:0] REG_PULSE = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_POWER = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_SHORT = 2'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_CLEAR = 2'd3;

	// Register reset values
	localparam logic [CFG_WIDTH-1:0] PULSE_RST = 16'd40;
	localparam logic [CFG_WIDTH-1:0] POWER_RST = 16'd4100;
	localparam logic [CFG_WIDTH-1:0] SHORT_RST = 16'd100;
	localparam logic [CFG_WIDTH-1:0] CLEAR_RST = 16'd6200;

	// Display commands and address windows
	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] CMD_SET_ADDR = 8'h80;
	localparam logic [7:0] ROW0_LAST    = 8'd39;
	localparam logic [7:0] ROW1_FIRST   = 8'd64;
	localparam logic [7:0] ROW1_LAST    = 8'd103;

	localparam logic [3:0] INIT_STEPS      = 4'd12;
	localparam logic [3:0] INIT_FIRST_NIB  = 4'h2;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] pulse_ticks;
		logic [CFG_WIDTH-1:0] power_on_wait_ticks;
		logic [CFG_WIDTH-1:0] short_wait_ticks;
		logic [CFG_WIDTH-1:0] clear_wait_ticks;
	} cfg_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] value;
		logic [3:0] bus_in;
	} item_t;

	typedef struct packed {
		logic       rejected;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       ready_res;
		logic       bus_drive;
		logic [3:0] bus_out;
		logic       enable_pin;
		logic       read_not_write;
		logic       reg_select;
	} res_t;

	// Nibble sent at a given init step (step counted from 0)
	function automatic logic [3:0] init_nibble(input logic [3:0] idx);
		logic [3:0] n;
		case (idx)
			4'd0, 4'd1, 4'd2, 4'd3, 4'd4: n = 4'h2;
			4'd5:  n = 4'h8;
			4'd7:  n = 4'hC;
			4'd9:  n = 4'h1;
			4'd11: n = 4'h6;
			default: n = 4'h0;
		endcase
		return n;
	endfunction

	// Wait that follows a given init step
	function automatic wait_kind_t init_wait(input logic [3:0] idx);
		wait_kind_t k;
		case (idx)
			4'd0: k = WK_POWER;
			4'd1: k = WK_SHORT;
			4'd9: k = WK_CLEAR;
			default: k = WK_NONE;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

FILE: src/clnbs_seq_core.sv
// Sequencer state, one-item next-state logic and the result register.
`default_nettype none
`include "char_lcd_nibble_bus_sequencer_macros.svh"

module clnbs_seq_core #(
	parameter int unsigned COUNT_WIDTH = clnbs_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire clnbs_pkg::item_t item,
	input  wire clnbs_pkg::cfg_t  cfg,
	output clnbs_pkg::res_t       res
);
	import clnbs_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_WR_HIGH = 3'd1,
		PH_WR_LOW  = 3'd2,
		PH_WAIT    = 3'd3,
		PH_RD_HIGH = 3'd4,
		PH_RD_LOW  = 3'd5
	} phase_t;

	localparam logic [31:0] CMAX32 = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

	// Zero counts as one, oversize saturates to the counter range
	function automatic logic [COUNT_WIDTH-1:0] load_count(input logic [CFG_WIDTH-1:0] v);
		logic [31:0] w;
		w = {{(32-CFG_WIDTH){1'b0}}, v};
		if (w == 32'd0) w = 32'd1;
		if (w > CMAX32) w = CMAX32;
		return w[COUNT_WIDTH-1:0];
	endfunction

	phase_t                 phase_q, n_phase;
	logic [3:0]             init_step_q, n_init_step;
	logic [COUNT_WIDTH-1:0] wait_q, n_wait;
	logic [7:0]             pending_q, n_pending;
	logic                   low_next_q, n_low_next;
	logic [7:0]             rd_asm_q, n_rd_asm;
	logic [3:0]             nib_q, n_nib;
	logic                   e_q, n_e;
	logic                   rs_q, n_rs;
	logic                   rw_q, n_rw;
	logic                   drive_q, n_drive;
	res_t                   res_q, n_res;

	logic                   done;
	logic [COUNT_WIDTH-1:0] pulse_ld;
	logic                   an_go, nn_go, wr_start;
	logic [3:0]             wr_nib;
	wait_kind_t             kind;
	logic [CFG_WIDTH-1:0]   wait_len;
	logic                   rej, rd_valid;
	logic [7:0]             rd_byte;
	logic [7:0]             byte_in;
	logic                   addr_ok;

	assign done     = (wait_q <= COUNT_WIDTH'(1));
	assign pulse_ld = load_count(cfg.pulse_ticks);
	assign byte_in  = item.value;
	assign addr_ok  = (byte_in <= ROW0_LAST) ||
		((byte_in >= ROW1_FIRST) && (byte_in <= ROW1_LAST));

	// Next state for one item
	always_comb begin
		n_phase     = phase_q;
		n_init_step = init_step_q;
		n_wait      = wait_q;
		n_pending   = pending_q;
		n_low_next  = low_next_q;
		n_rd_asm    = rd_asm_q;
		n_nib       = nib_q;
		n_e         = e_q;
		n_rs        = rs_q;
		n_rw        = rw_q;
		n_drive     = drive_q;
		an_go       = 1'b0;
		nn_go       = 1'b0;
		wr_start    = 1'b0;
		wr_nib      = 4'h0;
		kind        = WK_NONE;
		wait_len    = '0;
		rej         = 1'b0;
		rd_valid    = 1'b0;
		rd_byte     = 8'h00;

		if (item.op == OP_TICK) begin
			// count down the current phase
			if (phase_q != PH_IDLE) begin
				n_wait = done ? '0 : wait_q - COUNT_WIDTH'(1);
			end
			case (phase_q)
				PH_IDLE: begin
				end
				PH_WR_HIGH: begin
					if (done) begin
						n_e     = 1'b0;
						n_phase = PH_WR_LOW;
						n_wait  = pulse_ld;
					end
				end
				PH_WR_LOW: begin
					an_go = done;
				end
				PH_WAIT: begin
					nn_go = done;
				end
				PH_RD_HIGH: begin
					if (done) begin
						n_rd_asm = low_next_q ? {rd_asm_q[7:4], item.bus_in}
							: {item.bus_in, 4'h0};
						n_e      = 1'b0;
						n_phase  = PH_RD_LOW;
						n_wait   = pulse_ld;
					end
				end
				PH_RD_LOW: begin
					if (done) begin
						if (!low_next_q) begin
							n_low_next = 1'b1;
							n_e        = 1'b1;
							n_phase    = PH_RD_HIGH;
							n_wait     = pulse_ld;
						end else begin
							n_low_next = 1'b0;
							n_phase    = PH_IDLE;
							n_rw       = 1'b0;
							n_drive    = 1'b1;
							rd_valid   = 1'b1;
							rd_byte    = rd_asm_q;
						end
					end
				end
				default: begin
					n_phase = PH_IDLE;
				end
			endcase
		end else if (item.op <= OP_READ) begin
			if (phase_q != PH_IDLE) begin
				rej = 1'b1;
			end else begin
				case (item.op)
					OP_INIT: begin
						n_rs        = 1'b0;
						n_rw        = 1'b0;
						n_drive     = 1'b1;
						n_low_next  = 1'b0;
						n_init_step = 4'd1;
						wr_start    = 1'b1;
						wr_nib      = INIT_FIRST_NIB;
					end
					OP_CMD, OP_DATA: begin
						n_rs       = (item.op == OP_DATA);
						n_rw       = 1'b0;
						n_drive    = 1'b1;
						n_pending  = byte_in;
						n_low_next = 1'b1;
						wr_start   = 1'b1;
						wr_nib     = byte_in[7:4];
					end
					OP_ADDR: begin
						if (addr_ok) begin
							n_rs       = 1'b0;
							n_rw       = 1'b0;
							n_drive    = 1'b1;
							n_pending  = CMD_SET_ADDR | byte_in;
							n_low_next = 1'b1;
							wr_start   = 1'b1;
							wr_nib     = n_pending[7:4];
						end else begin
							rej = 1'b1;
						end
					end
					OP_READ: begin
						n_rw       = 1'b1;
						n_rs       = 1'b0;
						n_drive    = 1'b0;
						n_nib      = 4'h0;
						n_low_next = 1'b0;
						n_rd_asm   = 8'h00;
						n_e        = 1'b1;
						n_phase    = PH_RD_HIGH;
						n_wait     = pulse_ld;
					end
					default: begin
					end
				endcase
			end
		end

		// wait that follows a finished nibble
		if (an_go) begin
			if (init_step_q != 4'd0) begin
				kind = init_wait(init_step_q - 4'd1);
			end else if (!low_next_q && !rs_q && (pending_q == CMD_CLEAR)) begin
				kind = WK_CLEAR;
			end
			case (kind)
				WK_POWER: wait_len = cfg.power_on_wait_ticks;
				WK_SHORT: wait_len = cfg.short_wait_ticks;
				WK_CLEAR: wait_len = cfg.clear_wait_ticks;
				default:  wait_len = '0;
			endcase
			if (kind != WK_NONE) begin
				n_phase = PH_WAIT;
				n_wait  = load_count(wait_len);
			end else begin
				nn_go = 1'b1;
			end
		end

		// pick the next nibble or go idle
		if (nn_go) begin
			if (init_step_q != 4'd0) begin
				if (init_step_q >= INIT_STEPS) begin
					n_init_step = 4'd0;
					n_phase     = PH_IDLE;
				end else begin
					n_init_step = init_step_q + 4'd1;
					wr_start    = 1'b1;
					wr_nib      = init_nibble(init_step_q);
				end
			end else if (low_next_q) begin
				n_low_next = 1'b0;
				wr_start   = 1'b1;
				wr_nib     = pending_q[3:0];
			end else begin
				n_phase = PH_IDLE;
			end
		end

		// start an enable pulse for a write nibble
		if (wr_start) begin
			n_nib   = wr_nib;
			n_e     = 1'b1;
			n_phase = PH_WR_HIGH;
			n_wait  = pulse_ld;
		end

		n_res.reg_select     = n_rs;
		n_res.read_not_write = n_rw;
		n_res.enable_pin     = n_e;
		n_res.bus_out        = n_drive ? n_nib : 4'h0;
		n_res.bus_drive      = n_drive;
		n_res.ready_res      = (n_phase == PH_IDLE);
		n_res.read_valid     = rd_valid;
		n_res.read_byte      = rd_byte;
		n_res.rejected       = rej;
	end

	// State and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			init_step_q <= 4'd0;
			wait_q      <= '0;
			pending_q   <= 8'h00;
			low_next_q  <= 1'b0;
			rd_asm_q    <= 8'h00;
			nib_q       <= 4'h0;
			e_q         <= 1'b0;
			rs_q        <= 1'b0;
			rw_q        <= 1'b0;
			drive_q     <= 1'b1;
			res_q       <= '0;
		end else if (step) begin
			phase_q     <= n_phase;
			init_step_q <= n_init_step;
			wait_q      <= n_wait;
			pending_q   <= n_pending;
			low_next_q  <= n_low_next;
			rd_asm_q    <= n_rd_asm;
			nib_q       <= n_nib;
			e_q         <= n_e;
			rs_q        <= n_rs;
			rw_q        <= n_rw;
			drive_q     <= n_drive;
			res_q       <= n_res;
		end
	end

	assign res = res_q;

	// enable is never left high once idle
	`CLNBS_ASSERT_IMPL(a_idle_e_low, clk, arst_n, phase_q == PH_IDLE, !e_q)
	// data pins are released only inside a status read
	`CLNBS_ASSERT_IMPL(a_release_read, clk, arst_n, !drive_q,
		(phase_q == PH_RD_HIGH) || (phase_q == PH_RD_LOW))
	// RW high only while the bus is released
	`CLNBS_ASSERT_IMPL(a_rw_release, clk, arst_n, rw_q, !drive_q)
	// a refused request leaves the state as it was
	`CLNBS_ASSERT_NEXT(a_rej_hold, clk, arst_n, step && rej,
		$stable(phase_q) && $stable(wait_q) && $stable(pending_q))

endmodule

`default_nettype wire

FILE: src/char_lcd_nibble_bus_sequencer.sv
// Top level of the character display nibble-bus sequencer.
//
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tuser: op[2:0]; tdata: value[7:0], bus_in[11:8]
// m_axis    out  tdata: reg_select, read_not_write, enable_pin, bus_out[6:3],
//                bus_drive, ready_res, read_valid, read_byte[17:10], rejected
// cfg       in   cfg_we, cfg_index (0..3), cfg_wdata[15:0]
//
// One item every clock while the output is not stalled: an input register, one pass
// of next-state logic and a result register; the sequencer state is updated as the
// item leaves the input register.
// A result is offered once its item has passed the input register and then the
// result register.
// Reset clears all state but the input item register: sequencer idle, pins low,
// bus driven, registers at their default counts.
// A stalled output holds the result; one more item waits in the input register.
`default_nettype none

module char_lcd_nibble_bus_sequencer #(
	parameter int unsigned COUNT_WIDTH = clnbs_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [15:0]                         s_tdata,  // value[7:0], bus_in[11:8]
	input  wire logic [2:0]                          s_tuser,  // op[2:0]
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// reg_select, read_not_write, enable_pin, bus_out[6:3], bus_drive,
	// ready_res, read_valid, read_byte[17:10], rejected
	output logic [23:0]                              m_tdata,
	input  wire logic                                cfg_we,
	input  wire logic [clnbs_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  wire logic [clnbs_pkg::CFG_WIDTH-1:0]     cfg_wdata
);
	import clnbs_pkg::*;

	cfg_t  cfg_q;
	item_t item_s1;
	logic  valid_s1;
	logic  out_valid_q;
	logic  advance;
	res_t  res;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_ticks         <= PULSE_RST;
			cfg_q.power_on_wait_ticks <= POWER_RST;
			cfg_q.short_wait_ticks    <= SHORT_RST;
			cfg_q.clear_wait_ticks    <= CLEAR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PULSE: cfg_q.pulse_ticks         <= cfg_wdata;
				REG_POWER: cfg_q.power_on_wait_ticks <= cfg_wdata;
				REG_SHORT: cfg_q.short_wait_ticks    <= cfg_wdata;
				REG_CLEAR: cfg_q.clear_wait_ticks    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Input register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.op     <= s_tuser;
			item_s1.value  <= s_tdata[7:0];
			item_s1.bus_in <= s_tdata[11:8];
		end
	end

	clnbs_seq_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, res};

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the display nibble-bus sequencer: directed and random items.
`timescale 1ns / 100ps

module testbench;
	import clnbs_pkg::*;

	// Limit on simulated cycles; a run that reaches it is reported as a mismatch.
	localparam int unsigned CYCLE_LIMIT = 200_000;

	typedef enum logic [2:0] {
		S_IDLE,
		S_NIB_HIGH,
		S_NIB_LOW,
		S_HOLD,
		S_RD_HIGH,
		S_RD_LOW
	} seq_state_t;

	// Init nibbles, step 0 in the lowest nibble
	localparam logic [47:0] INIT_NIBS = {4'h6, 4'h0, 4'h1, 4'h0, 4'hC, 4'h0,
		4'h8, 4'h2, 4'h2, 4'h2, 4'h2, 4'h2};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'h0;
	logic [2:0]  s_tuser = 3'h0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_WIDTH-1:0]     cfg_wdata = '0;

	char_lcd_nibble_bus_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),  // value[7:0], bus_in[11:8]
		.s_tuser   (s_tuser),  // op[2:0]
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),  // reg_select, read_not_write, enable_pin, bus_out[6:3],
		                       // bus_drive, ready_res, read_valid, read_byte[17:10], rejected
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Predicted sequencer state
	cfg_t        counts;
	seq_state_t  seq_state;
	logic [3:0]  init_pos;
	logic [15:0] wait_left;
	logic [7:0]  byte_hold;
	logic        second_nib;
	logic [7:0]  rd_acc;
	logic        p_rs, p_rw, p_e, p_drv;
	logic [3:0]  p_nib;

	res_t pending_pins[$];
	int   error_count = 0;
	int   burst_left = 0;
	int   hold_cycles = 0;
	int   rx_count = 0;
	int   rx_style = 0;
	int unsigned cycle_count = 0;

	function automatic void reset_sequencer();
		counts.pulse_ticks = PULSE_RST;
		counts.power_on_wait_ticks = POWER_RST;
		counts.short_wait_ticks = SHORT_RST;
		counts.clear_wait_ticks = CLEAR_RST;
		seq_state = S_IDLE;
		init_pos = 4'd0;
		wait_left = 16'd0;
		byte_hold = 8'd0;
		second_nib = 1'b0;
		rd_acc = 8'd0;
		p_rs = 1'b0;
		p_rw = 1'b0;
		p_e = 1'b0;
		p_drv = 1'b1;
		p_nib = 4'd0;
	endfunction

	// A zero count behaves as one
	function automatic logic [15:0] load_ticks(input logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

	function automatic bit count_expired();
		if (wait_left <= 16'd1) begin
			wait_left = 16'd0;
			return 1'b1;
		end
		wait_left = wait_left - 16'd1;
		return 1'b0;
	endfunction

	function automatic void drive_nibble(input logic [3:0] n);
		p_nib = n;
		p_e = 1'b1;
		seq_state = S_NIB_HIGH;
		wait_left = load_ticks(counts.pulse_ticks);
	endfunction

	function automatic void strobe_read();
		p_e = 1'b1;
		seq_state = S_RD_HIGH;
		wait_left = load_ticks(counts.pulse_ticks);
	endfunction

	function automatic void advance_nibble();
		if (init_pos != 4'd0) begin
			if (init_pos >= INIT_STEPS) begin
				init_pos = 4'd0;
				seq_state = S_IDLE;
			end else begin
				init_pos = init_pos + 4'd1;
				drive_nibble(INIT_NIBS[{init_pos - 4'd1, 2'b00} +: 4]);
			end
		end else if (second_nib) begin
			second_nib = 1'b0;
			drive_nibble(byte_hold[3:0]);
		end else begin
			seq_state = S_IDLE;
		end
	endfunction

	// Pick the extra wait that follows a finished nibble, if any
	function automatic void finish_nibble();
		wait_kind_t  kind;
		logic [15:0] len;
		kind = WK_NONE;
		len = 16'd0;
		if (init_pos != 4'd0) begin
			case (init_pos)
				4'd1: kind = WK_POWER;
				4'd2: kind = WK_SHORT;
				4'd10: kind = WK_CLEAR;
				default: kind = WK_NONE;
			endcase
		end else if (!second_nib && !p_rs && byte_hold == CMD_CLEAR) begin
			kind = WK_CLEAR;
		end
		case (kind)
			WK_POWER: len = counts.power_on_wait_ticks;
			WK_SHORT: len = counts.short_wait_ticks;
			WK_CLEAR: len = counts.clear_wait_ticks;
			default: len = 16'd0;
		endcase
		if (kind != WK_NONE) begin
			seq_state = S_HOLD;
			wait_left = load_ticks(len);
		end else begin
			advance_nibble();
		end
	endfunction

	function automatic void launch_byte(input logic [7:0] b, input logic data);
		p_rs = data;
		p_rw = 1'b0;
		p_drv = 1'b1;
		byte_hold = b;
		second_nib = 1'b1;
		drive_nibble(b[7:4]);
	endfunction

	// Pin levels and flags that one item leaves behind
	function automatic res_t step_sequencer(input logic [2:0] op, input logic [7:0] value,
			input logic [3:0] bus_in);
		res_t r;
		logic rej, rv;
		logic [7:0] rb;
		rej = 1'b0;
		rv = 1'b0;
		rb = 8'd0;
		if (op == OP_TICK) begin
			case (seq_state)
				S_NIB_HIGH: if (count_expired()) begin
					p_e = 1'b0;
					seq_state = S_NIB_LOW;
					wait_left = load_ticks(counts.pulse_ticks);
				end
				S_NIB_LOW: if (count_expired()) finish_nibble();
				S_HOLD: if (count_expired()) advance_nibble();
				S_RD_HIGH: if (count_expired()) begin
					// sample on the last tick with enable high
					if (second_nib)
						rd_acc[3:0] = bus_in;
					else
						rd_acc = {bus_in, 4'h0};
					p_e = 1'b0;
					seq_state = S_RD_LOW;
					wait_left = load_ticks(counts.pulse_ticks);
				end
				S_RD_LOW: if (count_expired()) begin
					if (!second_nib) begin
						second_nib = 1'b1;
						strobe_read();
					end else begin
						second_nib = 1'b0;
						seq_state = S_IDLE;
						p_rw = 1'b0;
						p_drv = 1'b1;
						rv = 1'b1;
						rb = rd_acc;
					end
				end
				default: ;
			endcase
		end else if (op <= OP_READ) begin
			if (seq_state != S_IDLE) begin
				rej = 1'b1;
			end else begin
				case (op)
					OP_INIT: begin
						p_rs = 1'b0;
						p_rw = 1'b0;
						p_drv = 1'b1;
						second_nib = 1'b0;
						init_pos = 4'd1;
						drive_nibble(INIT_FIRST_NIB);
					end
					OP_CMD: launch_byte(value, 1'b0);
					OP_DATA: launch_byte(value, 1'b1);
					OP_ADDR: begin
						if (value <= ROW0_LAST || (value >= ROW1_FIRST && value <= ROW1_LAST))
							launch_byte(CMD_SET_ADDR | value, 1'b0);
						else
							rej = 1'b1;
					end
					default: begin
						p_rw = 1'b1;
						p_rs = 1'b0;
						p_drv = 1'b0;
						p_nib = 4'h0;
						second_nib = 1'b0;
						rd_acc = 8'd0;
						strobe_read();
					end
				endcase
			end
		end
		r.reg_select = p_rs;
		r.read_not_write = p_rw;
		r.enable_pin = p_e;
		r.bus_out = p_drv ? p_nib : 4'h0;
		r.bus_drive = p_drv;
		r.ready_res = (seq_state == S_IDLE);
		r.read_valid = rv;
		r.read_byte = rb;
		r.rejected = rej;
		return r;
	endfunction

	// Sender: bursts of items with random gaps between them
	task automatic send_item(input logic [2:0] op, input logic [7:0] value,
			input logic [3:0] bus_in);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {4'h0, bus_in, value};
		do @(posedge clk); while (!s_tready);
		pending_pins.push_back(step_sequencer(op, value, bus_in));
		burst_left--;
	endtask

	task automatic send_tick();
		send_item(OP_TICK, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
	endtask

	task automatic run_ticks_until_idle(input bit rand_bus, input logic [3:0] fixed_bus);
		while (seq_state != S_IDLE)
			send_item(OP_TICK, 8'($urandom_range(0, 255)),
				rand_bus ? 4'($urandom_range(0, 15)) : fixed_bus);
	endtask

	// Stop sending and wait until every expected item has come out
	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_pins.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic idle_and_configure(input logic [15:0] pulse_v, input logic [15:0] power_v,
			input logic [15:0] brief_v, input logic [15:0] clear_v);
		run_ticks_until_idle(1'b1, 4'h0);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_PULSE;
		cfg_wdata <= pulse_v;
		@(posedge clk);
		cfg_index <= REG_POWER;
		cfg_wdata <= power_v;
		@(posedge clk);
		cfg_index <= REG_SHORT;
		cfg_wdata <= brief_v;
		@(posedge clk);
		cfg_index <= REG_CLEAR;
		cfg_wdata <= clear_v;
		@(posedge clk);
		cfg_we <= 1'b0;
		counts.pulse_ticks = pulse_v;
		counts.power_on_wait_ticks = power_v;
		counts.short_wait_ticks = brief_v;
		counts.clear_wait_ticks = clear_v;
	endtask

	// One mostly well-formed request: init, command, data, address or status read; some addresses fall outside
	task automatic send_random_request();
		logic [2:0] op;
		logic [7:0] v;
		int pick;
		pick = $urandom_range(0, 19);
		v = 8'($urandom_range(0, 255));
		if (pick == 0) begin
			op = OP_INIT;
		end else if (pick < 6) begin
			op = OP_CMD;
			if ($urandom_range(0, 3) == 0)
				v = CMD_CLEAR;
		end else if (pick < 11) begin
			op = OP_DATA;
		end else if (pick < 16) begin
			op = OP_ADDR;
			if ($urandom_range(0, 3) != 0)
				v = $urandom_range(0, 1) ? 8'($urandom_range(0, 39)) : 8'($urandom_range(64, 103));
		end else begin
			op = OP_READ;
		end
		send_item(op, v, 4'($urandom_range(0, 15)));
	endtask

	task automatic send_mixed_item();
		if (seq_state == S_IDLE && $urandom_range(0, 3) != 0)
			send_random_request();
		else if ($urandom_range(0, 15) == 0)
			send_item(3'($urandom_range(1, 7)), 8'($urandom_range(0, 255)),
				4'($urandom_range(0, 15)));
		else
			send_tick();
	endtask

	// Byte write with the reset pulse count, init, requests while busy, unused ops
	task automatic test_power_up_init();
		send_item(OP_CMD, 8'h55, 4'h0);
		send_item(OP_INIT, 8'h00, 4'h0);
		send_item(OP_DATA, 8'hAA, 4'hF);
		send_item(3'd7, 8'hFF, 4'hF);
		run_ticks_until_idle(1'b1, 4'h0);
		send_item(3'd6, 8'h12, 4'h3);
		idle_and_configure(16'd1, 16'd5, 16'd3, 16'd4);
		send_item(OP_INIT, 8'h00, 4'h0);
		send_item(OP_CMD, 8'h55, 4'h0);
		send_item(OP_READ, 8'h00, 4'h0);
		run_ticks_until_idle(1'b1, 4'h0);
	endtask

	// Command and data bytes; only a clear command adds the clear wait
	task automatic test_byte_writes();
		idle_and_configure(16'd2, 16'd3, 16'd3, 16'd5);
		send_item(OP_CMD, CMD_CLEAR, 4'h0);
		run_ticks_until_idle(1'b1, 4'h0);
		send_item(OP_CMD, 8'hFF, 4'h0);
		run_ticks_until_idle(1'b1, 4'h0);
		send_item(OP_DATA, 8'h00, 4'h0);
		run_ticks_until_idle(1'b1, 4'h0);
		send_item(OP_DATA, CMD_CLEAR, 4'h0);
		run_ticks_until_idle(1'b1, 4'h0);
		send_item(OP_DATA, 8'hFF, 4'h0);
		run_ticks_until_idle(1'b1, 4'h0);
	endtask

	// Both address windows, their edges, and values just outside
	task automatic test_address_window();
		logic [7:0] addrs [8];
		addrs = '{8'd0, 8'd39, 8'd40, 8'd63, 8'd64, 8'd103, 8'd104, 8'd255};
		foreach (addrs[i]) begin
			send_item(OP_ADDR, addrs[i], 4'h0);
			run_ticks_until_idle(1'b1, 4'h0);
		end
	endtask

	// Status reads with the bus held all ones, then all zeros
	task automatic test_status_read();
		send_item(OP_READ, 8'h00, 4'hF);
		run_ticks_until_idle(1'b0, 4'hF);
		send_item(OP_READ, 8'hFF, 4'h0);
		run_ticks_until_idle(1'b0, 4'h0);
	endtask

	// All counts zero behave as one
	task automatic test_zero_counts();
		idle_and_configure(16'd0, 16'd0, 16'd0, 16'd0);
		send_item(OP_INIT, 8'h00, 4'h0);
		run_ticks_until_idle(1'b1, 4'h0);
		send_item(OP_CMD, CMD_CLEAR, 4'h0);
		run_ticks_until_idle(1'b1, 4'h0);
		send_item(OP_READ, 8'h00, 4'h0);
		run_ticks_until_idle(1'b1, 4'h0);
	endtask

	// A count that reaches into the upper counter byte (long power-on wait in init), then a longer read pulse
	task automatic test_long_counts();
		idle_and_configure(16'd1, 16'h0102, 16'd3, 16'd2);
		send_item(OP_INIT, 8'h00, 4'h0);
		run_ticks_until_idle(1'b1, 4'h0);
		idle_and_configure(16'h0021, 16'd1, 16'd1, 16'd1);
		send_item(OP_READ, 8'h00, 4'h0);
		run_ticks_until_idle(1'b1, 4'h0);
	endtask

	// Receiver holds off while the sender keeps offering items
	task automatic test_backpressure();
		idle_and_configure(16'd1, 16'd2, 16'd2, 16'd2);
		hold_cycles = 80;
		repeat (40) send_mixed_item();
		settle();
	endtask

	task automatic test_random_traffic();
		for (int round = 0; round < 5; round++) begin
			idle_and_configure(16'($urandom_range(0, 4)), 16'($urandom_range(0, 40)),
				16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)));
			repeat (190) send_mixed_item();
		end
	endtask

	initial begin
		reset_sequencer();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_power_up_init();
		test_byte_writes();
		test_address_window();
		test_status_read();
		test_zero_counts();
		test_long_counts();
		test_backpressure();
		test_random_traffic();
		run_ticks_until_idle(1'b1, 4'h0);
		settle();
		if (error_count == 0)
			$display("char_lcd_nibble_bus_sequencer: match");
		else
			$display("char_lcd_nibble_bus_sequencer: mismatch");
		$finish;
	end

	// Receiver: a randomly picked stall style; hold-off overrides it
	always @(posedge clk) begin
		rx_count = rx_count + 1;
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			if (rx_count % 256 == 0)
				rx_style = $urandom_range(0, 3);
			case (rx_style)
				0: m_tready <= 1'b1;
				1: m_tready <= (rx_count % 3) != 0;
				2: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= $urandom_range(0, 7) != 0;
			endcase
		end
	end

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			error_count++;
			if (error_count < 200)
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endtask

	// Compare each output item with the oldest expectation
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pins.size() == 0) begin
				error_count++;
				$display("%0t: item with nothing expected, got %h", $time, m_tdata);
			end else begin
				want = pending_pins.pop_front();
				check_field("reg_select", 8'(want.reg_select), 8'(m_tdata[0]));
				check_field("read_not_write", 8'(want.read_not_write), 8'(m_tdata[1]));
				check_field("enable_pin", 8'(want.enable_pin), 8'(m_tdata[2]));
				check_field("bus_out", 8'(want.bus_out), 8'(m_tdata[6:3]));
				check_field("bus_drive", 8'(want.bus_drive), 8'(m_tdata[7]));
				check_field("ready_res", 8'(want.ready_res), 8'(m_tdata[8]));
				check_field("read_valid", 8'(want.read_valid), 8'(m_tdata[9]));
				check_field("read_byte", want.read_byte, m_tdata[17:10]);
				check_field("rejected", 8'(want.rejected), 8'(m_tdata[18]));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("char_lcd_nibble_bus_sequencer: mismatch");
			$finish;
		end
	end

endmodule

FILE: filelist.f
+incdir+src
src/clnbs_pkg.sv
src/clnbs_seq_core.sv
src/char_lcd_nibble_bus_sequencer.sv
bench/testbench.sv
